// ===== design/zcsw_pkg.sv =====
package zcsw_pkg;

    // Field widths
    localparam int SAMPLE_BITS   = 16;
    localparam int INDEX_BITS    = 32;
    localparam int LEN_BITS      = 24;
    localparam int LIMIT_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    // Compare widths: wide enough for both operands
    localparam int LW = (INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS;
    localparam int NW = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;
    localparam int PW = (SAMPLE_BITS + 1 > LIMIT_BITS + 1) ? SAMPLE_BITS + 1 : LIMIT_BITS + 1;

    localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = LEN_BITS'(2560);

    // Register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE,
        CFG_MIN_WAVE,
        CFG_MAX_WAVE,
        CFG_MIN_HALF,
        CFG_MAX_HALF,
        CFG_NEG_PEAK,
        CFG_P2P
    } cfg_idx_t;

    typedef struct packed {
        logic                         neg_to_pos_mode;
        logic [LEN_BITS-1:0]          min_wave_len;
        logic [LEN_BITS-1:0]          max_wave_len;
        logic [LEN_BITS-1:0]          min_neg_half_len;
        logic [LEN_BITS-1:0]          max_neg_half_len;
        logic signed [LIMIT_BITS-1:0] neg_peak_limit;
        logic [LIMIT_BITS-1:0]        p2p_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          gap_before;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]         start_index;
        logic [INDEX_BITS-1:0]         stop_index;
        logic [INDEX_BITS-1:0]         mid_crossing_index;
        logic signed [SAMPLE_BITS-1:0] neg_peak_value;
        logic [INDEX_BITS-1:0]         neg_peak_index;
        logic signed [SAMPLE_BITS-1:0] pos_peak_value;
        logic [INDEX_BITS-1:0]         pos_peak_index;
        logic [LIMIT_BITS-1:0]         peak_to_peak;
    } out_item_t;

endpackage

// ===== design/zero_crossing_slow_wave_detector.sv =====
// The closing sample is held in the input register; the result register loads from it
// when it is empty or being drained, and m_valid is driven from the result register.
// Throughput: one sample per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous): registers return to their defaults, no wave
// is open, the sample counter restarts at zero, and both channels are emptied.
module zero_crossing_slow_wave_detector
    import zcsw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data
);

    cfg_t      cfg;
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      out_free;
    logic      en;
    logic      hit;
    out_item_t result;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;
    assign en       = in_valid_reg && out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_item_reg;

    zcsw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    zcsw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .en      (en),
        .item    (in_item_reg),
        .hit     (hit),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (out_free) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && hit) begin
            out_item_reg <= result;
        end
    end

    // An empty input register always takes a request
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled while empty");

    // A sample held back by a full result register is kept
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("stalled sample lost");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("pending result overwritten");

endmodule

// ===== design/zcsw_cfg.sv =====
module zcsw_cfg
    import zcsw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg          = cfg_reg;

    // Register decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:     cfg_next.neg_to_pos_mode  = cfg_data[0];
                CFG_MIN_WAVE: cfg_next.min_wave_len     = cfg_data[LEN_BITS-1:0];
                CFG_MAX_WAVE: cfg_next.max_wave_len     = cfg_data[LEN_BITS-1:0];
                CFG_MIN_HALF: cfg_next.min_neg_half_len = cfg_data[LEN_BITS-1:0];
                CFG_MAX_HALF: cfg_next.max_neg_half_len = cfg_data[LEN_BITS-1:0];
                CFG_NEG_PEAK: cfg_next.neg_peak_limit   = $signed(cfg_data[LIMIT_BITS-1:0]);
                CFG_P2P:      cfg_next.p2p_limit        = cfg_data[LIMIT_BITS-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.neg_to_pos_mode  <= 1'b0;
            cfg_reg.min_wave_len     <= '0;
            cfg_reg.max_wave_len     <= MAX_LEN_RESET;
            cfg_reg.min_neg_half_len <= '0;
            cfg_reg.max_neg_half_len <= MAX_LEN_RESET;
            cfg_reg.neg_peak_limit   <= '0;
            cfg_reg.p2p_limit        <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/zcsw_core.sv =====
module zcsw_core
    import zcsw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      en,
    input  in_item_t  item,
    output logic      hit,
    output out_item_t result
);

    // Tracking state
    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                          prev_valid_reg, prev_valid_next;
    logic [INDEX_BITS-1:0]         count_reg, count_next;
    logic                          open_reg, open_next;
    logic [INDEX_BITS-1:0]         start_reg, start_next;
    logic [INDEX_BITS-1:0]         cur_off_reg, cur_off_next;
    logic                          gap_seen_reg, gap_seen_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next, max_reg, max_next;
    logic [INDEX_BITS-1:0]         min_idx_reg, min_idx_next, max_idx_reg, max_idx_next;
    logic [INDEX_BITS-1:0]         min_off_reg, min_off_next, max_off_reg, max_off_next;
    logic                          opp_none_reg, opp_none_next;
    logic [INDEX_BITS-1:0]         opp_idx_reg, opp_idx_next, opp_off_reg, opp_off_next;
    logic                          cmin_none_reg, cmin_none_next;
    logic [INDEX_BITS-1:0]         cmin_idx_reg, cmin_idx_next, cmin_off_reg, cmin_off_next;
    logic                          cmax_none_reg, cmax_none_next;
    logic [INDEX_BITS-1:0]         cmax_idx_reg, cmax_idx_next, cmax_off_reg, cmax_off_next;

    logic signed [SAMPLE_BITS-1:0] s;
    logic                          down, up, bound, opposite;

    // Wave close checks
    logic                          min_later;
    logic [INDEX_BITS-1:0]         first_off, mid_idx, mid_off, half;
    logic                          mid_none;
    logic                          len_ok, mid_ok, half_ok, neg_ok, p2p_ok, pass;
    logic signed [PW-1:0]          diff;

    // Crossing detection, zero counts as positive
    assign s        = item.sample;
    assign down     = prev_valid_reg && !prev_reg[SAMPLE_BITS-1] && s[SAMPLE_BITS-1];
    assign up       = prev_valid_reg && prev_reg[SAMPLE_BITS-1] && !s[SAMPLE_BITS-1];
    assign bound    = cfg.neg_to_pos_mode ? up : down;
    assign opposite = cfg.neg_to_pos_mode ? down : up;

    // Pick the middle crossing recorded at the later peak
    assign min_later = min_off_reg >= max_off_reg;
    assign first_off = min_later ? max_off_reg : min_off_reg;
    assign mid_idx   = min_later ? cmin_idx_reg : cmax_idx_reg;
    assign mid_off   = min_later ? cmin_off_reg : cmax_off_reg;
    assign mid_none  = min_later ? cmin_none_reg : cmax_none_reg;
    assign half      = cfg.neg_to_pos_mode ? (cur_off_reg - mid_off) : mid_off;

    assign len_ok  = (cfg.min_wave_len == '0)
                  || !((LW'(cur_off_reg) < LW'(cfg.min_wave_len))
                    || (LW'(cur_off_reg) > LW'(cfg.max_wave_len)));
    assign mid_ok  = !mid_none && !(mid_off < first_off);
    assign half_ok = (cfg.min_neg_half_len == '0)
                  || !((LW'(half) < LW'(cfg.min_neg_half_len))
                    || (LW'(half) > LW'(cfg.max_neg_half_len)));
    assign neg_ok  = !cfg.neg_peak_limit[LIMIT_BITS-1]
                  || !(NW'(min_reg) > NW'(cfg.neg_peak_limit));
    assign diff    = PW'(max_reg) - PW'(min_reg);
    assign p2p_ok  = (cfg.p2p_limit == '0) || ($unsigned(diff) >= PW'(cfg.p2p_limit));
    assign pass    = !(gap_seen_reg || item.gap_before) && len_ok && mid_ok && half_ok
                  && neg_ok && p2p_ok;

    assign hit = en && bound && open_reg && pass;

    // Result fields
    always_comb begin
        result.start_index        = start_reg;
        result.stop_index         = count_reg;
        result.mid_crossing_index = mid_idx;
        result.neg_peak_value     = min_reg;
        result.neg_peak_index     = min_idx_reg;
        result.pos_peak_value     = max_reg;
        result.pos_peak_index     = max_idx_reg;
        result.peak_to_peak       = (|diff[PW-1:LIMIT_BITS]) ? '1 : diff[LIMIT_BITS-1:0];
    end

    // State update for one sample
    always_comb begin
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        count_next      = count_reg;
        open_next       = open_reg;
        start_next      = start_reg;
        cur_off_next    = cur_off_reg;
        gap_seen_next   = gap_seen_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        min_idx_next    = min_idx_reg;
        max_idx_next    = max_idx_reg;
        min_off_next    = min_off_reg;
        max_off_next    = max_off_reg;
        opp_none_next   = opp_none_reg;
        opp_idx_next    = opp_idx_reg;
        opp_off_next    = opp_off_reg;
        cmin_none_next  = cmin_none_reg;
        cmin_idx_next   = cmin_idx_reg;
        cmin_off_next   = cmin_off_reg;
        cmax_none_next  = cmax_none_reg;
        cmax_idx_next   = cmax_idx_reg;
        cmax_off_next   = cmax_off_reg;
        if (en) begin
            prev_next       = s;
            prev_valid_next = 1'b1;
            count_next      = count_reg + INDEX_BITS'(1);
            cur_off_next    = cur_off_reg + INDEX_BITS'(1);
            if (bound) begin
                // open a new wave at this crossing
                open_next      = 1'b1;
                start_next     = count_reg;
                cur_off_next   = INDEX_BITS'(1);
                gap_seen_next  = 1'b0;
                min_next       = s;
                max_next       = s;
                min_idx_next   = count_reg;
                max_idx_next   = count_reg;
                min_off_next   = '0;
                max_off_next   = '0;
                opp_none_next  = 1'b1;
                cmin_none_next = 1'b1;
                cmax_none_next = 1'b1;
            end else if (open_reg) begin
                if (item.gap_before) begin
                    gap_seen_next = 1'b1;
                end
                if (opposite) begin
                    opp_none_next = 1'b0;
                    opp_idx_next  = count_reg;
                    opp_off_next  = cur_off_reg;
                end
                if (s < min_reg) begin
                    min_next       = s;
                    min_idx_next   = count_reg;
                    min_off_next   = cur_off_reg;
                    cmin_none_next = opp_none_next;
                    cmin_idx_next  = opp_idx_next;
                    cmin_off_next  = opp_off_next;
                end
                if (s > max_reg) begin
                    max_next       = s;
                    max_idx_next   = count_reg;
                    max_off_next   = cur_off_reg;
                    cmax_none_next = opp_none_next;
                    cmax_idx_next  = opp_idx_next;
                    cmax_off_next  = opp_off_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
            count_reg      <= '0;
            open_reg       <= 1'b0;
            gap_seen_reg   <= 1'b0;
            opp_none_reg   <= 1'b1;
            cmin_none_reg  <= 1'b1;
            cmax_none_reg  <= 1'b1;
        end else begin
            prev_valid_reg <= prev_valid_next;
            count_reg      <= count_next;
            open_reg       <= open_next;
            gap_seen_reg   <= gap_seen_next;
            opp_none_reg   <= opp_none_next;
            cmin_none_reg  <= cmin_none_next;
            cmax_none_reg  <= cmax_none_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg     <= prev_next;
        start_reg    <= start_next;
        cur_off_reg  <= cur_off_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        min_idx_reg  <= min_idx_next;
        max_idx_reg  <= max_idx_next;
        min_off_reg  <= min_off_next;
        max_off_reg  <= max_off_next;
        opp_idx_reg  <= opp_idx_next;
        opp_off_reg  <= opp_off_next;
        cmin_idx_reg <= cmin_idx_next;
        cmin_off_reg <= cmin_off_next;
        cmax_idx_reg <= cmax_idx_next;
        cmax_off_reg <= cmax_off_next;
    end

    // A result only closes an open wave at a bounding crossing
    a_hit_at_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hit |-> (bound && open_reg))
        else $error("result without open wave at bounding crossing");

    // Gap anywhere in the wave suppresses the result
    a_hit_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        hit |-> !(gap_seen_reg || item.gap_before))
        else $error("result across a gap");

    // Running peaks stay ordered while a wave is open
    a_peak_order: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> (min_reg <= max_reg))
        else $error("running minimum above running maximum");

    // The wave offset tracks the sample counter
    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> (count_reg - start_reg == cur_off_reg))
        else $error("wave offset out of step with counter");

endmodule

// ===== tb/sv/zcsw_checker.sv =====
`timescale 1ns / 1ps

// Watches the config, sample and wave channels, predicts detected waves and
// compares them against what the detector reports.
module zcsw_checker
    import zcsw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  in_item_t                 s_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  out_item_t                m_data,
    output int                       fail_count,
    output int                       waves_due
);

    // top bit flags "no crossing seen yet"
    localparam logic [INDEX_BITS:0] NO_CROSSING = {1'b1, {INDEX_BITS{1'b0}}};

    cfg_t                          regs;
    logic signed [SAMPLE_BITS-1:0] last_sample;
    logic signed [SAMPLE_BITS-1:0] lo_val;
    logic signed [SAMPLE_BITS-1:0] hi_val;
    logic                          have_last;
    logic                          in_wave;
    logic                          gap_hit;
    logic [INDEX_BITS-1:0]         sample_idx;
    logic [INDEX_BITS-1:0]         wave_begin;
    logic [INDEX_BITS-1:0]         lo_idx;
    logic [INDEX_BITS-1:0]         hi_idx;
    logic [INDEX_BITS:0]           mid_seen;
    logic [INDEX_BITS:0]           mid_at_lo;
    logic [INDEX_BITS:0]           mid_at_hi;
    out_item_t                     due_waves[$];
    int                            mismatches;

    initial begin
        mismatches = 0;
    end

    // Decide whether the wave closing at 'stop' is reported, and what it reports
    function automatic bit judge_wave(input logic [INDEX_BITS-1:0] stop, output out_item_t w);
        logic [INDEX_BITS-1:0] len;
        logic [INDEX_BITS-1:0] mid;
        logic [INDEX_BITS-1:0] early_peak;
        logic [INDEX_BITS-1:0] half;
        logic [INDEX_BITS:0]   mid_raw;
        logic                  lo_later;
        int                    swing;
        len        = stop - wave_begin;
        lo_later   = (lo_idx - wave_begin) >= (hi_idx - wave_begin);
        early_peak = lo_later ? hi_idx : lo_idx;
        mid_raw    = lo_later ? mid_at_lo : mid_at_hi;
        mid        = mid_raw[INDEX_BITS-1:0];
        w          = '0;
        if (gap_hit)
            return 1'b0;
        if (regs.min_wave_len != 0 &&
            (len < regs.min_wave_len || len > regs.max_wave_len))
            return 1'b0;
        if (mid_raw[INDEX_BITS])
            return 1'b0;
        if ((mid - wave_begin) < (early_peak - wave_begin))
            return 1'b0;
        half = regs.neg_to_pos_mode ? (stop - mid) : (mid - wave_begin);
        if (regs.min_neg_half_len != 0 &&
            (half < regs.min_neg_half_len || half > regs.max_neg_half_len))
            return 1'b0;
        if ($signed(regs.neg_peak_limit) < 0 && lo_val > $signed(regs.neg_peak_limit))
            return 1'b0;
        swing = int'(hi_val) - int'(lo_val);
        if (regs.p2p_limit != 0 && swing < int'(regs.p2p_limit))
            return 1'b0;
        w.start_index        = wave_begin;
        w.stop_index         = stop;
        w.mid_crossing_index = mid;
        w.neg_peak_value     = lo_val;
        w.neg_peak_index     = lo_idx;
        w.pos_peak_value     = hi_val;
        w.pos_peak_index     = hi_idx;
        w.peak_to_peak       = (swing > 65535) ? 16'hFFFF : swing[15:0];
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [INDEX_BITS-1:0] want,
                               input logic [INDEX_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t             w;
        out_item_t             seen;
        in_item_t              it;
        logic                  down;
        logic                  up;
        logic                  bound;
        logic                  opp;
        logic [INDEX_BITS-1:0] idx;
        if (!aresetn) begin
            regs                  = '0;
            regs.max_wave_len     = MAX_LEN_RESET;
            regs.max_neg_half_len = MAX_LEN_RESET;
            last_sample = '0;
            have_last   = 1'b0;
            sample_idx  = '0;
            in_wave     = 1'b0;
            wave_begin  = '0;
            gap_hit     = 1'b0;
            lo_val      = '0;
            hi_val      = '0;
            lo_idx      = '0;
            hi_idx      = '0;
            mid_seen    = NO_CROSSING;
            mid_at_lo   = NO_CROSSING;
            mid_at_hi   = NO_CROSSING;
            due_waves.delete();
        end else begin
            // register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MODE:     regs.neg_to_pos_mode  = cfg_data[0];
                    CFG_MIN_WAVE: regs.min_wave_len     = cfg_data[LEN_BITS-1:0];
                    CFG_MAX_WAVE: regs.max_wave_len     = cfg_data[LEN_BITS-1:0];
                    CFG_MIN_HALF: regs.min_neg_half_len = cfg_data[LEN_BITS-1:0];
                    CFG_MAX_HALF: regs.max_neg_half_len = cfg_data[LEN_BITS-1:0];
                    CFG_NEG_PEAK: regs.neg_peak_limit   = cfg_data[LIMIT_BITS-1:0];
                    CFG_P2P:      regs.p2p_limit        = cfg_data[LIMIT_BITS-1:0];
                    default: ;
                endcase
            end

            // sample request: crossing search and running peaks
            if (s_valid && s_ready) begin
                it    = s_data;
                idx   = sample_idx;
                down  = have_last && !last_sample[SAMPLE_BITS-1] && it.sample[SAMPLE_BITS-1];
                up    = have_last && last_sample[SAMPLE_BITS-1] && !it.sample[SAMPLE_BITS-1];
                bound = regs.neg_to_pos_mode ? up : down;
                opp   = regs.neg_to_pos_mode ? down : up;
                if (bound) begin
                    if (in_wave) begin
                        if (it.gap_before)
                            gap_hit = 1'b1;
                        if (judge_wave(idx, w))
                            due_waves.insert(due_waves.size(), w);
                    end
                    in_wave    = 1'b1;
                    wave_begin = idx;
                    gap_hit    = 1'b0;
                    lo_val     = it.sample;
                    hi_val     = it.sample;
                    lo_idx     = idx;
                    hi_idx     = idx;
                    mid_seen   = NO_CROSSING;
                    mid_at_lo  = NO_CROSSING;
                    mid_at_hi  = NO_CROSSING;
                end else if (in_wave) begin
                    if (it.gap_before)
                        gap_hit = 1'b1;
                    if (opp)
                        mid_seen = {1'b0, idx};
                    // strict compares: first occurrence keeps the peak
                    if (it.sample < lo_val) begin
                        lo_val    = it.sample;
                        lo_idx    = idx;
                        mid_at_lo = mid_seen;
                    end
                    if (it.sample > hi_val) begin
                        hi_val    = it.sample;
                        hi_idx    = idx;
                        mid_at_hi = mid_seen;
                    end
                end
                last_sample = it.sample;
                have_last   = 1'b1;
                sample_idx  = sample_idx + 1'b1;
            end

            // wave request: compare with the oldest prediction
            if (m_valid && m_ready) begin
                seen = m_data;
                if (due_waves.size() == 0) begin
                    $display("%0t: wave reported, none expected (start %0h stop %0h)",
                             $time, seen.start_index, seen.stop_index);
                    mismatches++;
                end else begin
                    w = due_waves.pop_front();
                    check_field("start_index", w.start_index, seen.start_index);
                    check_field("stop_index", w.stop_index, seen.stop_index);
                    check_field("mid_crossing_index", w.mid_crossing_index,
                                seen.mid_crossing_index);
                    check_field("neg_peak_value", INDEX_BITS'(w.neg_peak_value),
                                INDEX_BITS'(seen.neg_peak_value));
                    check_field("neg_peak_index", w.neg_peak_index, seen.neg_peak_index);
                    check_field("pos_peak_value", INDEX_BITS'(w.pos_peak_value),
                                INDEX_BITS'(seen.pos_peak_value));
                    check_field("pos_peak_index", w.pos_peak_index, seen.pos_peak_index);
                    check_field("peak_to_peak", INDEX_BITS'(w.peak_to_peak),
                                INDEX_BITS'(seen.peak_to_peak));
                end
            end
        end
        waves_due  <= due_waves.size();
        fail_count <= mismatches;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb
    import zcsw_pkg::*;
();

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = '1;
    localparam int                      DIR_LEN   = 22;
    localparam int                      PHASE_LEN = 200;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    in_item_t                 s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    out_item_t                m_data;
    int                       fail_count;
    int                       waves_due;

    bit eager     = 1'b0;
    bit below     = 1'b0;
    int sent      = 0;
    int waves_got = 0;

    // directed opening: first sample, zero as positive, extremes, peak ties,
    // gap inside a wave and gap on the closing sample
    int dir_smp [DIR_LEN] = '{-100, 0, 32767, -32768, -32768, 0, 32767, 32767, -1, -7,
                              20, -20, -30, 50, 10, -5, -3, 1, 2, -2, 5, -9};
    bit dir_gap [DIR_LEN] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                              0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0};

    always #5 aclk = ~aclk;

    zero_crossing_slow_wave_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    zcsw_checker wave_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .waves_due  (waves_due)
    );

    // idle cycles before the next request; none at all in eager stretches
    function automatic int idle_draw();
        if (eager || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic gap);
        int hold;
        hold = idle_draw();
        if (hold > 0) begin
            s_valid <= 1'b0;
            repeat (hold) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{sample: smp, gap_before: gap};
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // one half-wave of random content, or a short burst of noise
    task automatic send_segment();
        int len;
        int amp;
        int v;
        if ($urandom_range(0, 6) == 0) begin
            len = $urandom_range(1, 4);
            repeat (len) begin
                v = $urandom_range(0, 65535);
                send_sample(v[SAMPLE_BITS-1:0], $urandom_range(0, 39) == 0);
            end
        end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            amp = ($urandom_range(0, 7) == 0) ? 32767 : $urandom_range(1, 32767);
            repeat (len) begin
                if (below)
                    v = -int'($urandom_range(1, amp + 1));
                else if ($urandom_range(0, 15) == 0)
                    v = 0;
                else
                    v = $urandom_range(0, amp);
                send_sample(v[SAMPLE_BITS-1:0], $urandom_range(0, 39) == 0);
            end
            below = !below;
        end
    endtask

    // stop offering and wait until every predicted wave is out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (waves_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // unused bits of the narrow registers carry random junk
    task automatic apply_setting(input logic mode, input logic [LEN_BITS-1:0] min_w,
                                 input logic [LEN_BITS-1:0] max_w,
                                 input logic [LEN_BITS-1:0] min_h,
                                 input logic [LEN_BITS-1:0] max_h,
                                 input logic [LIMIT_BITS-1:0] neg_lim,
                                 input logic [LIMIT_BITS-1:0] p2p_lim);
        logic [CFG_DATA_BITS-1:0] junk;
        junk = CFG_DATA_BITS'($urandom);
        write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
        write_reg(CFG_MODE, {junk[CFG_DATA_BITS-1:1], mode});
        write_reg(CFG_MIN_WAVE, min_w);
        write_reg(CFG_MAX_WAVE, max_w);
        write_reg(CFG_MIN_HALF, min_h);
        write_reg(CFG_MAX_HALF, max_h);
        junk = CFG_DATA_BITS'($urandom);
        write_reg(CFG_NEG_PEAK, {junk[CFG_DATA_BITS-1:LIMIT_BITS], neg_lim});
        junk = CFG_DATA_BITS'($urandom);
        write_reg(CFG_P2P, {junk[CFG_DATA_BITS-1:LIMIT_BITS], p2p_lim});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_setting();
        int min_w;
        int min_h;
        int neg;
        min_w = $urandom_range(0, 12);
        min_h = $urandom_range(0, 6);
        neg   = ($urandom_range(0, 1) == 0) ? 0 : -int'($urandom_range(1, 20000));
        apply_setting(1'($urandom_range(0, 1)), LEN_BITS'(min_w),
                      LEN_BITS'(min_w + int'($urandom_range(0, 30))),
                      LEN_BITS'(min_h), LEN_BITS'(min_h + int'($urandom_range(0, 16))),
                      neg[LIMIT_BITS-1:0],
                      LIMIT_BITS'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30000)));
    endtask

    // wave sink: random back-pressure plus one long hold-off to fill the block
    initial begin
        int hold;
        forever begin
            hold = idle_draw();
            if (waves_got == 25)
                hold = 400;
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            waves_got++;
        end
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    // stimulus and verdict
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_LEN; i++)
            send_sample(dir_smp[i][SAMPLE_BITS-1:0], dir_gap[i]);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            eager = (phase % 3 == 1);
            case (phase)
                0: apply_setting(1'b1, 6, 30, 2, 14, -16'sd2000, 4000);
                1: apply_setting(1'b0, 8, 24, 3, 12, -16'sd500, 1000);
                2: apply_setting(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                 16'h8000, 16'hFFFF);
                3: apply_setting(1'b0, 1, 24'hFFFFFF, 1, 24'hFFFFFF, 16'hFFFF, 1);
                6: apply_setting(1'b1, 0, 0, 0, 0, 0, 0);
                default: random_setting();
            endcase
            while (sent < DIR_LEN + (phase + 1) * PHASE_LEN)
                send_segment();
            drain();
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && waves_due == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== zero_crossing_slow_wave_detector.f =====
design/zcsw_pkg.sv
design/zcsw_cfg.sv
design/zcsw_core.sv
design/zero_crossing_slow_wave_detector.sv
tb/sv/zcsw_checker.sv
tb/sv/tb.sv
